FILE: rtl/nacf_pkg.sv
// ----------------------------------------------------------------------------
// nacf_pkg
// shared widths, register indexes and sideband types of the acf error estimator
// ----------------------------------------------------------------------------
package nacf_pkg;

    localparam int P_W    = 32;
    localparam int S_W    = 35;
    localparam int A2_W   = 31;
    localparam int U_W    = 31;
    localparam int B_W    = 33;
    localparam int H_W    = 32;
    localparam int G_W    = 34;
    localparam int ROOT_W = 30;
    localparam int AVG_W  = 10;
    localparam int IDX_W  = 8;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic [IDX_W-1:0] {
        CFG_MODE      = 8'd0,
        CFG_NOISE     = 8'd1,
        CFG_SIG_AVG   = 8'd2,
        CFG_NOISE_AVG = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic last;
        logic zero;
    } nacf_tag_t;

    typedef struct packed {
        logic [P_W-1:0] p;
        logic [S_W-1:0] s;
        nacf_tag_t      tag;
    } nacf_gate_t;

endpackage

FILE: rtl/nacf_div_pipe.sv
// ----------------------------------------------------------------------------
// nacf_div_pipe
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module nacf_div_pipe #(
    parameter int DEN_W = 32,
    parameter int QUO_W = 32,
    parameter int SB_W  = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [QUO_W+DEN_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    input  logic [SB_W-1:0]        in_sb,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo,
    output logic [SB_W-1:0]        out_sb
);

    logic             valid_reg [QUO_W];
    logic [DEN_W-1:0] rem_reg   [QUO_W];
    logic [QUO_W-1:0] word_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [SB_W-1:0]  sb_reg    [QUO_W];

    logic             valid_next [QUO_W];
    logic [DEN_W-1:0] rem_next   [QUO_W];
    logic [QUO_W-1:0] word_next  [QUO_W];
    logic [DEN_W-1:0] den_next   [QUO_W];
    logic [SB_W-1:0]  sb_next    [QUO_W];

    logic [DEN_W-1:0] src_rem;
    logic [QUO_W-1:0] src_word;
    logic [DEN_W:0]   bring;
    logic [DEN_W+1:0] diff;

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
                src_rem       = num[QUO_W+DEN_W-1:QUO_W];
                src_word      = num[QUO_W-1:0];
                den_next[k]   = den;
                sb_next[k]    = in_sb;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                src_rem       = rem_reg[k-1];
                src_word      = word_reg[k-1];
                den_next[k]   = den_reg[k-1];
                sb_next[k]    = sb_reg[k-1];
            end
            bring = {src_rem, src_word[QUO_W-1]};
            diff  = {1'b0, bring} - {2'b00, den_next[k]};
            if (!diff[DEN_W+1])
            begin
                rem_next[k]  = diff[DEN_W-1:0];
                word_next[k] = {src_word[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = bring[DEN_W-1:0];
                word_next[k] = {src_word[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                word_reg[k] <= word_next[k];
                den_reg[k]  <= den_next[k];
                sb_reg[k]   <= sb_next[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = word_reg[QUO_W-1];
    assign out_sb    = sb_reg[QUO_W-1];

endmodule

FILE: rtl/nacf_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// nacf_sqrt_pipe
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module nacf_sqrt_pipe #(
    parameter int ROOT_W = 30,
    parameter int SB_W   = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*ROOT_W-1:0] rad,
    input  logic [SB_W-1:0]     in_sb,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output logic [SB_W-1:0]     out_sb
);

    localparam int RW = ROOT_W + 3;

    logic                valid_reg [ROOT_W];
    logic [RW-1:0]       rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]   root_reg  [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg   [ROOT_W];
    logic [SB_W-1:0]     sb_reg    [ROOT_W];

    logic                valid_next [ROOT_W];
    logic [RW-1:0]       rem_next   [ROOT_W];
    logic [ROOT_W-1:0]   root_next  [ROOT_W];
    logic [2*ROOT_W-1:0] rad_next   [ROOT_W];
    logic [SB_W-1:0]     sb_next    [ROOT_W];

    logic [RW-1:0]       src_rem;
    logic [ROOT_W-1:0]   src_root;
    logic [2*ROOT_W-1:0] src_rad;
    logic [RW-1:0]       bring;
    logic [RW-1:0]       trial;
    logic [RW:0]         diff;

    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
                src_rem       = '0;
                src_root      = '0;
                src_rad       = rad;
                sb_next[k]    = in_sb;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                src_rem       = rem_reg[k-1];
                src_root      = root_reg[k-1];
                src_rad       = rad_reg[k-1];
                sb_next[k]    = sb_reg[k-1];
            end
            bring = {src_rem[RW-3:0], src_rad[2*ROOT_W-1:2*ROOT_W-2]};
            trial = {1'b0, src_root, 2'b01};
            diff  = {1'b0, bring} - {1'b0, trial};
            rad_next[k] = {src_rad[2*ROOT_W-3:0], 2'b00};
            if (!diff[RW])
            begin
                rem_next[k]  = diff[RW-1:0];
                root_next[k] = {src_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = bring;
                root_next[k] = {src_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
                sb_reg[k]   <= sb_next[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_sb    = sb_reg[ROOT_W-1];

endmodule

FILE: rtl/nacf_poly.sv
// ----------------------------------------------------------------------------
// nacf_poly
// five stage multiply pipeline forming the signal term b and noise term h
// ----------------------------------------------------------------------------
module nacf_poly (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     mode,
    input  logic                     in_valid,
    input  logic [nacf_pkg::A2_W-1:0] a2,
    input  logic [nacf_pkg::U_W-1:0] u30,
    input  logic [nacf_pkg::U_W-1:0] w30,
    input  nacf_pkg::nacf_gate_t     in_sb,
    output logic                     out_valid,
    output logic [nacf_pkg::B_W-1:0] b,
    output logic [nacf_pkg::H_W-1:0] h,
    output nacf_pkg::nacf_gate_t     out_sb
);

    import nacf_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [61:0]     sq1_reg, w2p1_reg;
    logic [32:0]     m1_reg, m2_reg, m3_reg, m4_reg;
    logic [A2_W-1:0] a2_1_reg;
    logic [U_W-1:0]  u1_reg, u2_reg, u3_reg;
    logic [31:0]     t2_reg, coef2_reg, w2_2_reg, coef3_reg, coef4_reg;
    logic [63:0]     tu3_reg, h3_reg, q4_reg;
    logic [31:0]     h4_reg, h5_reg;
    logic [B_W-1:0]  b5_reg;
    nacf_gate_t      sb1_reg, sb2_reg, sb3_reg, sb4_reg, sb5_reg;

    logic [61:0] sq1_next, m1_prod, w2p1_next;
    logic [31:0] t2_next, coef2_next;
    logic [63:0] tu3_next, h3_next, q4_next;
    logic [34:0] b_sum;
    logic [B_W-1:0] b5_next;

    always_comb
    begin
        sq1_next  = {31'b0, a2} * {31'b0, a2};
        m1_prod   = {31'b0, a2} * {31'b0, u30};
        w2p1_next = {31'b0, w30} * {31'b0, w30};
        if (mode)
        begin
            t2_next    = {1'b0, a2_1_reg};
            coef2_next = ONE_Q30 + {a2_1_reg, 1'b0};
        end
        else
        begin
            t2_next    = {1'b0, a2_1_reg} + sq1_reg[61:30];
            coef2_next = ONE_Q30 + {1'b0, a2_1_reg};
        end
        tu3_next = {32'b0, t2_reg} * {33'b0, u2_reg};
        h3_next  = {32'b0, w2_2_reg} * {32'b0, coef2_reg};
        q4_next  = {32'b0, tu3_reg[61:30]} * {33'b0, u3_reg};
        b_sum    = {3'b0, coef4_reg} + {3'b0, q4_reg[61:30]} - {2'b0, m4_reg};
        b5_next  = b_sum[34] ? '0 : b_sum[B_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg   <= sq1_next;
            m1_reg    <= m1_prod[60:28];
            w2p1_reg  <= w2p1_next;
            a2_1_reg  <= a2;
            u1_reg    <= u30;
            sb1_reg   <= in_sb;

            t2_reg    <= t2_next;
            coef2_reg <= coef2_next;
            w2_2_reg  <= w2p1_reg[61:30];
            m2_reg    <= m1_reg;
            u2_reg    <= u1_reg;
            sb2_reg   <= sb1_reg;

            tu3_reg   <= tu3_next;
            h3_reg    <= h3_next;
            coef3_reg <= coef2_reg;
            m3_reg    <= m2_reg;
            u3_reg    <= u2_reg;
            sb3_reg   <= sb2_reg;

            q4_reg    <= q4_next;
            h4_reg    <= h3_reg[61:30];
            coef4_reg <= coef3_reg;
            m4_reg    <= m3_reg;
            sb4_reg   <= sb3_reg;

            b5_reg    <= b5_next;
            h5_reg    <= h4_reg;
            sb5_reg   <= sb4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign b         = b5_reg;
    assign h         = h5_reg;
    assign out_sb    = sb5_reg;

endmodule

FILE: rtl/normalized_acf_error_estimator.sv
// ----------------------------------------------------------------------------
// normalized_acf_error_estimator
// standard error of the normalized acf per range gate, rho_1 or rho_2 form
// ----------------------------------------------------------------------------
// One gate is taken per clock while the output side keeps taking results; the
// pipeline is built from bit-per-stage units and register stages: 31 stages
// for the power ratio dividers, 5 multiply stages, 33 stages for the
// averaging dividers, 30 for the square root, 32 for the final quotient and
// five single register stages. A stall on the output holds the whole
// pipeline. Configuration must be written only while no gate is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module normalized_acf_error_estimator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        lag0_power,
    input  logic [31:0]        clutter_power,
    input  logic signed [15:0] norm_acf,
    input  logic               last_gate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        error_value,
    output logic               zero_power_flag,
    output logic               saturated_flag,
    output logic               last_gate_out
);

    import nacf_pkg::*;

    localparam int USB_W = P_W + S_W + A2_W;
    localparam int PS_W  = P_W + S_W;
    localparam int TAG_W = $bits(nacf_tag_t);
    localparam int GT_W  = $bits(nacf_gate_t);

    logic             mode_reg;
    logic [31:0]      noise_reg;
    logic [AVG_W-1:0] savg_reg, navg_reg;
    logic [AVG_W-1:0] k_eff, kn_eff;

    logic en;

    // input stage
    logic             v0_reg;
    logic [P_W-1:0]   p0_reg;
    logic [S_W-1:0]   s0_reg;
    logic [A2_W-1:0]  a2_0_reg;
    nacf_tag_t        tag0_reg;
    logic signed [31:0] acf_sq;

    // ratio dividers
    logic             vu, vw;
    logic [U_W-1:0]   u30, w30;
    logic [USB_W-1:0] usb;
    logic [TAG_W-1:0] wsb;
    nacf_gate_t       poly_sb_in, poly_sb_out;

    logic             vp;
    logic [B_W-1:0]   b_val;
    logic [H_W-1:0]   h_val;

    // averaging dividers
    logic             vbk, vhk;
    logic [B_W-1:0]   bq;
    logic [H_W-1:0]   hq;
    logic [B_W-1:0]   hq_wide;
    logic [PS_W-1:0]  bsb;
    logic [TAG_W-1:0] hsb;

    logic             vg_reg;
    logic [G_W-1:0]   g_reg;
    nacf_gate_t       gsb_reg;

    logic             vr;
    logic [ROOT_W-1:0] root;
    logic [GT_W-1:0]  rsb;
    nacf_gate_t       rgate;

    logic             vm_reg;
    logic [64:0]      prod_reg;
    logic [P_W-1:0]   pm_reg;
    nacf_tag_t        tagm_reg;

    logic             vs_reg;
    logic [63:0]      num_s_reg;
    logic [P_W-1:0]   ps_reg;
    nacf_tag_t        tags_reg;
    logic             sat_s_reg;
    logic [63:0]      xs_next;
    logic             sat_next;

    logic             vf;
    logic [31:0]      fq;
    logic [TAG_W:0]   fsb;
    nacf_tag_t        ftag;
    logic             fsat;

    logic             out_valid_reg;
    logic [31:0]      error_reg;
    logic             zero_reg, sat_reg, last_reg;
    logic [31:0]      error_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            noise_reg <= '0;
            savg_reg  <= AVG_W'(1);
            navg_reg  <= AVG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:      mode_reg  <= cfg_data[0];
                CFG_NOISE:     noise_reg <= cfg_data;
                CFG_SIG_AVG:   savg_reg  <= cfg_data[AVG_W-1:0];
                CFG_NOISE_AVG: navg_reg  <= cfg_data[AVG_W-1:0];
                default:       ;
            endcase
        end
    end

    assign k_eff  = (savg_reg == '0) ? AVG_W'(1) : savg_reg;
    assign kn_eff = (navg_reg == '0) ? AVG_W'(1) : navg_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign acf_sq = norm_acf * norm_acf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg        <= lag0_power;
            s0_reg        <= S_W'(lag0_power) + S_W'(noise_reg) + S_W'(clutter_power);
            a2_0_reg      <= acf_sq[A2_W-1:0];
            tag0_reg.last <= last_gate;
            tag0_reg.zero <= (lag0_power == '0);
        end
    end

    nacf_div_pipe #(.DEN_W(S_W), .QUO_W(U_W), .SB_W(USB_W)) u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .num       ({4'b0, p0_reg, 30'b0}),
        .den       (s0_reg),
        .in_sb     ({p0_reg, s0_reg, a2_0_reg}),
        .out_valid (vu),
        .quo       (u30),
        .out_sb    (usb)
    );

    nacf_div_pipe #(.DEN_W(S_W), .QUO_W(U_W), .SB_W(TAG_W)) u_div_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .num       ({4'b0, noise_reg, 30'b0}),
        .den       (s0_reg),
        .in_sb     (tag0_reg),
        .out_valid (vw),
        .quo       (w30),
        .out_sb    (wsb)
    );

    assign poly_sb_in.p   = usb[USB_W-1:S_W+A2_W];
    assign poly_sb_in.s   = usb[S_W+A2_W-1:A2_W];
    assign poly_sb_in.tag = nacf_tag_t'(wsb);

    nacf_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (mode_reg),
        .in_valid  (vu & vw),
        .a2        (usb[A2_W-1:0]),
        .u30       (u30),
        .w30       (w30),
        .in_sb     (poly_sb_in),
        .out_valid (vp),
        .b         (b_val),
        .h         (h_val),
        .out_sb    (poly_sb_out)
    );

    nacf_div_pipe #(.DEN_W(AVG_W), .QUO_W(B_W), .SB_W(PS_W)) u_div_k (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vp),
        .num       ({{AVG_W{1'b0}}, b_val}),
        .den       (k_eff),
        .in_sb     ({poly_sb_out.p, poly_sb_out.s}),
        .out_valid (vbk),
        .quo       (bq),
        .out_sb    (bsb)
    );

    nacf_div_pipe #(.DEN_W(AVG_W), .QUO_W(B_W), .SB_W(TAG_W)) u_div_kn (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vp),
        .num       ({{AVG_W{1'b0}}, 1'b0, h_val}),
        .den       (kn_eff),
        .in_sb     (poly_sb_out.tag),
        .out_valid (vhk),
        .quo       (hq_wide),
        .out_sb    (hsb)
    );

    assign hq = hq_wide[H_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vg_reg <= 1'b0;
        end
        else if (en)
        begin
            vg_reg <= vbk & vhk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg       <= {1'b0, bq} + {2'b0, hq};
            gsb_reg.p   <= bsb[PS_W-1:S_W];
            gsb_reg.s   <= bsb[S_W-1:0];
            gsb_reg.tag <= nacf_tag_t'(hsb);
        end
    end

    nacf_sqrt_pipe #(.ROOT_W(ROOT_W), .SB_W(GT_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vg_reg),
        .rad       ({g_reg, 26'b0}),
        .in_sb     (gsb_reg),
        .out_valid (vr),
        .root      (root),
        .out_sb    (rsb)
    );

    assign rgate = nacf_gate_t'(rsb);

    always_comb
    begin
        xs_next  = {11'b0, prod_reg[64:12]};
        sat_next = (xs_next >= {pm_reg, 32'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= vr;
            vs_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= {30'b0, rgate.s} * {35'b0, root};
            pm_reg    <= rgate.p;
            tagm_reg  <= rgate.tag;
            num_s_reg <= sat_next ? '0 : xs_next;
            ps_reg    <= pm_reg;
            tags_reg  <= tagm_reg;
            sat_s_reg <= sat_next;
        end
    end

    nacf_div_pipe #(.DEN_W(P_W), .QUO_W(32), .SB_W(TAG_W+1)) u_div_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs_reg),
        .num       (num_s_reg),
        .den       (ps_reg),
        .in_sb     ({tags_reg, sat_s_reg}),
        .out_valid (vf),
        .quo       (fq),
        .out_sb    (fsb)
    );

    assign ftag = nacf_tag_t'(fsb[TAG_W:1]);
    assign fsat = fsb[0];

    always_comb
    begin
        if (ftag.zero)
        begin
            error_next = '0;
        end
        else if (fsat)
        begin
            error_next = '1;
        end
        else
        begin
            error_next = fq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            error_reg <= error_next;
            zero_reg  <= ftag.zero;
            sat_reg   <= fsat & !ftag.zero;
            last_reg  <= ftag.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign error_value     = error_reg;
    assign zero_power_flag = zero_reg;
    assign saturated_flag  = sat_reg;
    assign last_gate_out   = last_reg;

endmodule

FILE: rtl/nacf_checker.sv
// ----------------------------------------------------------------------------
// nacf_props
// port level checks of the acf error estimator, bound to the top level
// ----------------------------------------------------------------------------
module nacf_props (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] error_value,
    input logic        zero_power_flag,
    input logic        saturated_flag,
    input logic        last_gate_out
);

    // zero power forces a zero result
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_power_flag |-> error_value == 32'h0)
        else $error("zero power result not zero");

    // clamp shows full scale
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated_flag |-> error_value == 32'hFFFF_FFFF)
        else $error("saturated result not full scale");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(zero_power_flag && saturated_flag))
        else $error("zero and saturated flags together");

    // stalled transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(error_value)
            && $stable(last_gate_out))
        else $error("output changed while stalled");

endmodule

bind normalized_acf_error_estimator nacf_props u_nacf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .error_value     (error_value),
    .zero_power_flag (zero_power_flag),
    .saturated_flag  (saturated_flag),
    .last_gate_out   (last_gate_out)
);
